// ----- rtl/core/w2s_pkg.sv -----
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared types and constants of the world-to-screen projector.
// ----------------------------------------------------------------------------
package w2s_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned SCREEN_W   = 29;
  localparam int unsigned CLIP_W     = 50;
  localparam int unsigned NUM_W      = 51;
  localparam int unsigned DEN_W      = 51;
  localparam int unsigned QUO_W      = 30;

  localparam logic signed [CLIP_W-1:0] NEAR_LIMIT = CLIP_W'(655);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_X_XY  = 3'd0,
    REG_COEF_X_ZT  = 3'd1,
    REG_COEF_Y_XY  = 3'd2,
    REG_COEF_Y_ZT  = 3'd3,
    REG_COEF_W_XY  = 3'd4,
    REG_COEF_W_ZT  = 3'd5,
    REG_VIEW_WIDTH = 3'd6,
    REG_VIEW_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_word_t;

  typedef struct packed {
    logic                visible;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
  } out_word_t;

endpackage

// ----- rtl/core/w2s_stream_if.sv -----
// ----------------------------------------------------------------------------
// w2s_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface w2s_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/w2s_divider.sv -----
// ----------------------------------------------------------------------------
// w2s_divider
// Pipelined restoring divider: floor(num * k / den), one quotient bit a stage.
// ----------------------------------------------------------------------------
module w2s_divider (
  input  logic                       clk,
  input  logic                       en,
  input  logic [w2s_pkg::NUM_W-1:0]  num,
  input  logic [w2s_pkg::SIZE_W-1:0] size,
  input  logic [w2s_pkg::DEN_W-1:0]  den,
  output logic [w2s_pkg::QUO_W-1:0]  quo
);
  import w2s_pkg::*;

  // Product num*size*65536 fits NUM_W+SIZE_W+16 bits; quotient below 2^QUO_W.
  localparam int unsigned PROD_W = NUM_W + SIZE_W + 16;
  localparam int unsigned STAGES = QUO_W;
  localparam int unsigned REM_W  = DEN_W + 1;

  // Multiply stage: split product into two 32-bit-ish halves, sum next stage
  logic [31+SIZE_W:0]       plo_r, phi_r;
  logic [DEN_W-1:0]         den0_r;
  logic [PROD_W-1:0]        prod_r;
  logic [DEN_W-1:0]         den1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r  <= {{SIZE_W{1'b0}}, num[31:0]} * {32'd0, size};
      phi_r  <= {{(32+SIZE_W-(NUM_W-32)){1'b0}}, num[NUM_W-1:32]} * {32'd0, size};
      den0_r <= den;
      prod_r <= (PROD_W'(phi_r) << 48) + (PROD_W'(plo_r) << 16);
      den1_r <= den0_r;
    end
  end

  // Long division: the quotient is below 2^QUO_W, so the top of the
  // product compared to den<<QUO_W is already smaller.
  logic [REM_W-1:0]  rem_r [STAGES];
  logic [PROD_W-1:0] dvd_r [STAGES];
  logic [QUO_W-1:0]  q_r   [STAGES];
  logic [DEN_W-1:0]  d_r   [STAGES];

  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_stage
      logic [REM_W-1:0]  rem_in;
      logic [PROD_W-1:0] dvd_in;
      logic [QUO_W-1:0]  q_in;
      logic [DEN_W-1:0]  d_in;
      logic [REM_W:0]    trial;
      if (g == 0) begin : g_first
        assign rem_in = REM_W'(prod_r >> QUO_W);
        assign dvd_in = prod_r;
        assign q_in   = '0;
        assign d_in   = den1_r;
      end else begin : g_next
        assign rem_in = rem_r[g-1];
        assign dvd_in = dvd_r[g-1];
        assign q_in   = q_r[g-1];
        assign d_in   = d_r[g-1];
      end
      assign trial = {rem_in, dvd_in[QUO_W-1-g]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (trial >= (REM_W+1)'(d_in)) begin
            rem_r[g] <= REM_W'(trial - (REM_W+1)'(d_in));
            q_r[g]   <= {q_in[QUO_W-2:0], 1'b1};
          end else begin
            rem_r[g] <= REM_W'(trial);
            q_r[g]   <= {q_in[QUO_W-2:0], 1'b0};
          end
          dvd_r[g] <= dvd_in;
          d_r[g]   <= d_in;
        end
      end
    end
  endgenerate

  assign quo = q_r[STAGES-1];
endmodule

// ----- rtl/core/world_to_screen_projector_top.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projector_top
// Perspective projection and viewport mapping of world points.
// ----------------------------------------------------------------------------
// channel | dir | word                               | handshake
// in      | in  | world_x, world_y, world_z (Q16.16) | valid/ready
// out     | out | visible, screen_x, screen_y        | valid/ready
// cfg     | in  | cfg_we, cfg_idx, cfg_data          | write strobe
//
// One word enters per cycle while the output is not stalled; the stages are dot product 3,
// checks 1, multiply 2, one divider stage per quotient bit 30. The pipeline advances
// only when the last stage is empty or taken, so a stall freezes all stages.
// Synchronous active-low reset clears the configuration registers and valid bits.
module world_to_screen_projector_top (
  input  logic                               clk,
  input  logic                               rst_n,
  w2s_stream_if.sink                         in_ch,
  w2s_stream_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [w2s_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [w2s_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import w2s_pkg::*;

  localparam int unsigned LAT = 6 + QUO_W;

  // Configuration registers
  logic [63:0]        cxy_r, czt_r, yxy_r, yzt_r, wxy_r, wzt_r;
  logic [SIZE_W-1:0]  vw_r, vh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cxy_r <= '0; czt_r <= '0; yxy_r <= '0; yzt_r <= '0;
      wxy_r <= '0; wzt_r <= '0; vw_r <= '0; vh_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_COEF_X_XY:   cxy_r <= cfg_data;
        REG_COEF_X_ZT:   czt_r <= cfg_data;
        REG_COEF_Y_XY:   yxy_r <= cfg_data;
        REG_COEF_Y_ZT:   yzt_r <= cfg_data;
        REG_COEF_W_XY:   wxy_r <= cfg_data;
        REG_COEF_W_ZT:   wzt_r <= cfg_data;
        REG_VIEW_WIDTH:  vw_r  <= cfg_data[SIZE_W-1:0];
        REG_VIEW_HEIGHT: vh_r  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid chain
  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv         = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // Stage 1: nine products, 32x32 each
  logic signed [63:0] p_r [9];
  logic signed [31:0] m_x [9];
  logic signed [31:0] tx_r, ty_r, tw_r;

  assign m_x[0] = cxy_r[63:32]; assign m_x[1] = cxy_r[31:0]; assign m_x[2] = czt_r[63:32];
  assign m_x[3] = yxy_r[63:32]; assign m_x[4] = yxy_r[31:0]; assign m_x[5] = yzt_r[63:32];
  assign m_x[6] = wxy_r[63:32]; assign m_x[7] = wxy_r[31:0]; assign m_x[8] = wzt_r[63:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p_r[3*i]   <= in_ch.data.world_x * m_x[3*i];
        p_r[3*i+1] <= in_ch.data.world_y * m_x[3*i+1];
        p_r[3*i+2] <= in_ch.data.world_z * m_x[3*i+2];
      end
      tx_r <= czt_r[31:0];
      ty_r <= yzt_r[31:0];
      tw_r <= wzt_r[31:0];
    end
  end

  // Stage 2: floor to Q16.16 (arithmetic shift), partial sums
  logic signed [CLIP_W-1:0] sa_r [3], sb_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sa_r[i] <= CLIP_W'(p_r[3*i] >>> 16) + CLIP_W'(p_r[3*i+1] >>> 16);
      end
      sb_r[0] <= CLIP_W'(p_r[2] >>> 16) + CLIP_W'(tx_r);
      sb_r[1] <= CLIP_W'(p_r[5] >>> 16) + CLIP_W'(ty_r);
      sb_r[2] <= CLIP_W'(p_r[8] >>> 16) + CLIP_W'(tw_r);
    end
  end

  // Stage 3: clip coordinates
  logic signed [CLIP_W-1:0] cx_r, cy_r, cw_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r <= sa_r[0] + sb_r[0];
      cy_r <= sa_r[1] + sb_r[1];
      cw_r <= sa_r[2] + sb_r[2];
    end
  end

  // Stage 4: visibility and divider operands
  logic              vis4_r;
  logic [NUM_W-1:0]  nx_r, ny_r;
  logic [DEN_W-1:0]  den_r;
  logic              vis_c;

  assign vis_c = (vw_r != '0) && (vh_r != '0) && (cw_r >= NEAR_LIMIT)
              && (cx_r <= cw_r) && (cx_r >= -cw_r)
              && (cy_r <= cw_r) && (cy_r >= -cw_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      vis4_r <= vis_c;
      nx_r   <= NUM_W'(cx_r + cw_r);
      ny_r   <= NUM_W'(cw_r - cy_r);
      den_r  <= vis_c ? {cw_r, 1'b0} : DEN_W'(1);
    end
  end

  // Divider lanes (2 multiply stages + QUO_W bit stages)
  logic [QUO_W-1:0] qx, qy;

  w2s_divider u_div_x (
    .clk(clk), .en(adv), .num(nx_r), .size(vw_r), .den(den_r), .quo(qx)
  );
  w2s_divider u_div_y (
    .clk(clk), .en(adv), .num(ny_r), .size(vh_r), .den(den_r), .quo(qy)
  );

  // Carry the visible flag alongside the divider
  logic [QUO_W+1:0] vsh_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      vsh_r <= {vsh_r[QUO_W:0], vis4_r};
    end
  end

  // Output word
  assign out_ch.valid         = vld_r[LAT-1];
  assign out_ch.data.visible  = vsh_r[QUO_W+1];
  assign out_ch.data.screen_x = vsh_r[QUO_W+1] ? SCREEN_W'(qx) : '0;
  assign out_ch.data.screen_y = vsh_r[QUO_W+1] ? SCREEN_W'(qy) : '0;
endmodule

// ----- tb/sv/world_to_screen_projector_top_tb.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projector_top_tb
// Drives world points through the projector under a series of view matrix
// and viewport settings and idle/stall patterns. Each accepted point is
// projected by a fixed-point model held in the bench. Every output word is
// checked field by field against the oldest projection still waiting.
// ----------------------------------------------------------------------------
module world_to_screen_projector_top_tb;
  import w2s_pkg::*;

  localparam int unsigned PHASES      = 16;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned DRAIN_CYC   = 60;
  localparam int unsigned STALL_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  w2s_stream_if #(.payload_t(in_word_t))  in_if ();
  w2s_stream_if #(.payload_t(out_word_t)) out_if ();

  world_to_screen_projector_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the register file
  logic [63:0]       sh_coef [6];
  logic [SIZE_W-1:0] sh_width;
  logic [SIZE_W-1:0] sh_height;

  in_word_t  pending_points [$];
  out_word_t projected_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned points_sent = 0;
  int unsigned words_seen = 0;
  int unsigned visible_seen = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  // Q16.16 dot product with floored products plus translation entry
  function automatic longint clip_dot(logic [63:0] rxy, logic [63:0] rzt,
                                      longint x, longint y, longint z);
    longint a;
    longint b;
    longint c;
    longint t;
    a = longint'($signed(rxy[63:32]));
    b = longint'($signed(rxy[31:0]));
    c = longint'($signed(rzt[63:32]));
    t = longint'($signed(rzt[31:0]));
    return ((x * a) >>> 16) + ((y * b) >>> 16) + ((z * c) >>> 16) + t;
  endfunction

  function automatic logic [SCREEN_W-1:0] scale_div(longint n, logic [SIZE_W-1:0] size,
                                                    longint d);
    logic [127:0] num;
    logic [127:0] q;
    num = 128'(n) * (128'(size) << 16);
    q = num / 128'(d);
    return q[SCREEN_W-1:0];
  endfunction

  function automatic out_word_t project_point(in_word_t p);
    out_word_t r;
    longint x;
    longint y;
    longint z;
    longint cx;
    longint cy;
    longint cw;
    x = longint'(p.world_x);
    y = longint'(p.world_y);
    z = longint'(p.world_z);
    cx = clip_dot(sh_coef[REG_COEF_X_XY], sh_coef[REG_COEF_X_ZT], x, y, z);
    cy = clip_dot(sh_coef[REG_COEF_Y_XY], sh_coef[REG_COEF_Y_ZT], x, y, z);
    cw = clip_dot(sh_coef[REG_COEF_W_XY], sh_coef[REG_COEF_W_ZT], x, y, z);
    r = '0;
    if (sh_width != 0 && sh_height != 0 && cw >= 655 &&
        cx <= cw && cx >= -cw && cy <= cw && cy >= -cw) begin
      r.visible  = 1'b1;
      r.screen_x = scale_div(cx + cw, sh_width, 2 * cw);
      r.screen_y = scale_div(cw - cy, sh_height, 2 * cw);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch on word %0d: %s got 0x%0h expected 0x%0h",
             words_seen, field, got, want);
  endtask

  // Write one register and track it in the shadow copy
  task automatic write_reg(cfg_reg_t r, logic [63:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (r == REG_VIEW_WIDTH) sh_width = v[SIZE_W-1:0];
    else if (r == REG_VIEW_HEIGHT) sh_height = v[SIZE_W-1:0];
    else sh_coef[r] = v;
  endtask

  function automatic logic [31:0] small_q16(int unsigned span);
    return 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
  endfunction

  // A plain perspective camera: x/y scaled, w taken from z
  task automatic load_camera(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    write_reg(REG_COEF_X_XY, {32'($urandom_range(32'h8000, 32'h20000)), small_q16(32'h1000)});
    write_reg(REG_COEF_X_ZT, {small_q16(32'h2000), small_q16(32'h100000)});
    write_reg(REG_COEF_Y_XY, {small_q16(32'h1000), 32'($urandom_range(32'h8000, 32'h20000))});
    write_reg(REG_COEF_Y_ZT, {small_q16(32'h2000), small_q16(32'h100000)});
    write_reg(REG_COEF_W_XY, {small_q16(32'h40), small_q16(32'h40)});
    write_reg(REG_COEF_W_ZT, {32'h0001_0000, small_q16(32'h800)});
    write_reg(REG_VIEW_WIDTH, 64'(w));
    write_reg(REG_VIEW_HEIGHT, 64'(h));
  endtask

  task automatic load_setting(int unsigned kind);
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    w = SIZE_W'($urandom_range(1, 4096));
    h = SIZE_W'($urandom_range(1, 4096));
    case (kind)
      0: load_camera(w, h);
      1: load_camera(13'd4096, 13'd1);
      2: begin
        // Fully random coefficients, every bit toggles
        for (int i = 0; i < 6; i++) write_reg(cfg_reg_t'(i), {$urandom, $urandom});
        write_reg(REG_VIEW_WIDTH, 64'($urandom));
        write_reg(REG_VIEW_HEIGHT, 64'($urandom));
      end
      3: begin
        load_camera(w, h);
        write_reg(REG_VIEW_WIDTH, 64'd0);
      end
      4: begin
        load_camera(13'd8191, 13'd8191);
        write_reg(REG_VIEW_HEIGHT, 64'd0);
      end
      default: begin
        // Extreme coefficient patterns
        write_reg(REG_COEF_X_XY, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_COEF_X_ZT, {32'hFFFF_FFFF, 32'h7FFF_FFFF});
        write_reg(REG_COEF_Y_XY, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(REG_COEF_Y_ZT, {32'h0000_0000, 32'h8000_0000});
        write_reg(REG_COEF_W_XY, {32'h0000_0000, 32'h0000_0000});
        write_reg(REG_COEF_W_ZT, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        write_reg(REG_VIEW_WIDTH, 64'd8191);
        write_reg(REG_VIEW_HEIGHT, 64'd4096);
      end
    endcase
  endtask

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_word_t p;
    p.world_x = x;
    p.world_y = y;
    p.world_z = z;
    pending_points.push_back(p);
  endtask

  // Mostly points inside or near the frustum, some raw noise
  task automatic push_random_point();
    int unsigned zz;
    if ($urandom_range(0, 99) < 80) begin
      zz = $urandom_range(1, 32'h3FFF_FFFF);
      push_point(32'($signed($urandom_range(0, 2 * zz)) - $signed(zz)),
                 32'($signed($urandom_range(0, 2 * zz)) - $signed(zz)), zz);
    end else begin
      push_point($urandom, $urandom, $urandom);
    end
  endtask

  // Hold until the block is empty, then let the pipeline settle; sample
  // away from the active edge so driver and monitor updates are visible
  task automatic wait_idle();
    @(negedge clk);
    while (pending_points.size() > 0 || projected_q.size() > 0 || in_if.valid)
      @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Driver: advance to the next point when the current word is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.data  <= pending_points.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: project accepted points, check accepted results
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (in_if.valid && in_if.ready) begin
        projected_q.push_back(project_point(in_if.data));
        points_sent++;
      end
      if (out_if.valid && out_if.ready) begin
        if (projected_q.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_if.data), 0);
        end else begin
          want = projected_q.pop_front();
          if (out_if.data.visible !== want.visible)
            report_mismatch("visible", out_if.data.visible, want.visible);
          if (out_if.data.screen_x !== want.screen_x)
            report_mismatch("screen_x", out_if.data.screen_x, want.screen_x);
          if (out_if.data.screen_y !== want.screen_y)
            report_mismatch("screen_y", out_if.data.screen_y, want.screen_y);
        end
        words_seen++;
        if (out_if.data.visible) visible_seen++;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
    sh_width = '0;
    sh_height = '0;
    for (int i = 0; i < 6; i++) sh_coef[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers give an empty viewport
    push_point(32'h0, 32'h0, 32'h0001_0000);
    wait_idle();
    write_reg(REG_COEF_X_XY, {32'h0001_0000, 32'h0});
    write_reg(REG_COEF_X_ZT, 64'h0);
    write_reg(REG_COEF_Y_XY, {32'h0, 32'h0001_0000});
    write_reg(REG_COEF_Y_ZT, 64'h0);
    write_reg(REG_COEF_W_XY, 64'h0);
    write_reg(REG_COEF_W_ZT, {32'h0001_0000, 32'h0});
    write_reg(REG_VIEW_WIDTH, 64'd4096);
    write_reg(REG_VIEW_HEIGHT, 64'd4096);
    push_point(32'h0, 32'h0, 32'h0001_0000);            // center
    push_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);  // on corner edge
    push_point(32'h0001_0001, 32'h0, 32'h0001_0000);     // just past right edge
    push_point(32'h0, 32'hFFFE_FFFF, 32'h0001_0000);     // just past bottom edge
    push_point(32'h0, 32'h0, 32'd655);                  // at near limit
    push_point(32'h0, 32'h0, 32'd654);                  // just under near limit
    push_point(32'd655, 32'hFFFF_FD71, 32'd655);         // edges at near limit
    push_point(32'h0, 32'h0, 32'h0);                    // zero depth
    push_point(32'h0, 32'h0, 32'hFFFF_0000);            // behind the camera
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
    wait_idle();
    write_reg(REG_VIEW_WIDTH, 64'd8191);
    write_reg(REG_VIEW_HEIGHT, 64'd1);
    push_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    push_point(32'h0, 32'h0, 32'h7FFF_FFFF);
    push_point(32'h3FFF_FFFF, 32'hC000_0001, 32'h7FFF_FFFF);

    // Random phases over settings and idle patterns
    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_idle();
      load_setting(p % 6);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) push_random_point();
    end

    wait_idle();
    $display("covered %0d points under %0d settings, %0d results, %0d visible",
             points_sent, PHASES + 3, words_seen, visible_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/w2s_pkg.sv
rtl/core/w2s_stream_if.sv
rtl/core/w2s_divider.sv
rtl/core/world_to_screen_projector_top.sv
tb/sv/world_to_screen_projector_top_tb.sv
